### hw/rtl/fmn_pkg.sv
`default_nettype none
package fmn_pkg;

   // Width of the numerator, the denominator and the magnitudes
   localparam int VALUE_WIDTH = 32;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
   localparam logic [CNT_WIDTH-1:0] DIV_LAST = CNT_WIDTH'(VALUE_WIDTH - 1);

   typedef enum logic [2:0] {
      KIND_NAN    = 3'd0,
      KIND_ZERO   = 3'd1,
      KIND_MIXED  = 3'd2,
      KIND_WHOLE  = 3'd3,
      KIND_PROPER = 3'd4
   } kind_type;

   // Operand and destination selection for the shared divider
   typedef enum logic [1:0] {
      DIV_OP_WHOLE = 2'd0,
      DIV_OP_NUM   = 2'd1,
      DIV_OP_DEN   = 2'd2
   } div_op_type;

   typedef struct packed {
      logic       load;
      logic       div_init;
      logic       div_step;
      logic       div_save;
      div_op_type div_op;
      logic       gcd_init;
      logic       gcd_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic rem_zero;
      logic gcd_done;
   } status_type;

endpackage
`default_nettype wire

### hw/rtl/fmn_dp.sv
`default_nettype none
module fmn_dp
   import fmn_pkg::*;
(
   input  wire logic                     clock,
   input  wire cmd_type                  cmd,
   input  wire logic [VALUE_WIDTH-1:0]   numerator,
   input  wire logic [VALUE_WIDTH-1:0]   denominator,
   output status_type                    status,
   output kind_type                      kind,
   output logic                          negative,
   output logic [VALUE_WIDTH-1:0]        whole_part,
   output logic [VALUE_WIDTH-2:0]        reduced_numerator,
   output logic [VALUE_WIDTH-1:0]        reduced_denominator
);

   logic                   n_zero_ff, d_zero_ff, neg_ff;
   logic [VALUE_WIDTH-1:0] an_ff, ad_ff;
   logic [VALUE_WIDTH-1:0] whole_ff, rn_ff, rd_ff;

   // shared restoring divider
   logic [VALUE_WIDTH-1:0] quo_ff, rem_ff, dvs_ff;
   logic [VALUE_WIDTH-1:0] quo_in, rem_in;
   logic [VALUE_WIDTH:0]   shifted, diff;
   logic                   fits;

   // binary gcd
   logic [VALUE_WIDTH-1:0] gu_ff, gv_ff;
   logic [CNT_WIDTH-1:0]   gk_ff;
   logic [VALUE_WIDTH-1:0] gcd_val;

   // output register
   kind_type               out_kind_ff, kind_in;
   logic                   out_neg_ff;
   logic [VALUE_WIDTH-1:0] out_whole_ff, out_rd_ff;
   logic [VALUE_WIDTH-2:0] out_rn_ff;

   assign shifted = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = ~diff[VALUE_WIDTH];
   assign rem_in  = fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
   assign quo_in  = {quo_ff[VALUE_WIDTH-2:0], fits};
   assign gcd_val = gu_ff << gk_ff;

   assign status.special  = n_zero_ff | d_zero_ff;
   assign status.rem_zero = (rn_ff == '0);
   assign status.gcd_done = (gv_ff == '0);

   always_comb begin
      if (d_zero_ff) begin
         kind_in = KIND_NAN;
      end else if (n_zero_ff) begin
         kind_in = KIND_ZERO;
      end else if (whole_ff != '0 && rn_ff != '0) begin
         kind_in = KIND_MIXED;
      end else if (whole_ff != '0) begin
         kind_in = KIND_WHOLE;
      end else begin
         kind_in = KIND_PROPER;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_zero_ff <= (numerator == '0);
         d_zero_ff <= (denominator == '0);
         neg_ff    <= (numerator != '0) && (denominator != '0) &&
                      (numerator[VALUE_WIDTH-1] != denominator[VALUE_WIDTH-1]);
         an_ff     <= numerator[VALUE_WIDTH-1] ? (~numerator + 1'b1) : numerator;
         ad_ff     <= denominator[VALUE_WIDTH-1] ? (~denominator + 1'b1) : denominator;
         whole_ff  <= '0;
         rn_ff     <= '0;
         rd_ff     <= '0;
      end

      if (cmd.div_init) begin
         rem_ff <= '0;
         case (cmd.div_op)
            DIV_OP_WHOLE: begin
               quo_ff <= an_ff;
               dvs_ff <= ad_ff;
            end
            DIV_OP_NUM: begin
               quo_ff <= rn_ff;
               dvs_ff <= gcd_val;
            end
            DIV_OP_DEN: begin
               quo_ff <= ad_ff;
               dvs_ff <= gcd_val;
            end
            default: begin
               quo_ff <= '0;
               dvs_ff <= ad_ff;
            end
         endcase
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end

      // store the finished quotient (and, for the whole part, the remainder) on the last step
      if (cmd.div_save) begin
         case (cmd.div_op)
            DIV_OP_WHOLE: begin
               whole_ff <= quo_in;
               rn_ff    <= rem_in;
            end
            DIV_OP_NUM: begin
               rn_ff <= quo_in;
            end
            DIV_OP_DEN: begin
               rd_ff <= quo_in;
            end
            default: begin
               rd_ff <= rd_ff;
            end
         endcase
      end

      if (cmd.gcd_init) begin
         gu_ff <= rn_ff;
         gv_ff <= ad_ff;
         gk_ff <= '0;
      end else if (cmd.gcd_step && gv_ff != '0) begin
         if (!gu_ff[0] && !gv_ff[0]) begin
            gu_ff <= gu_ff >> 1;
            gv_ff <= gv_ff >> 1;
            gk_ff <= gk_ff + 1'b1;
         end else if (!gu_ff[0]) begin
            gu_ff <= gu_ff >> 1;
         end else if (!gv_ff[0]) begin
            gv_ff <= gv_ff >> 1;
         end else if (gu_ff > gv_ff) begin
            gu_ff <= gv_ff;
            gv_ff <= gu_ff - gv_ff;
         end else begin
            gv_ff <= gv_ff - gu_ff;
         end
      end

      if (cmd.out_load) begin
         out_kind_ff  <= kind_in;
         out_neg_ff   <= neg_ff;
         out_whole_ff <= whole_ff;
         out_rn_ff    <= rn_ff[VALUE_WIDTH-2:0];
         out_rd_ff    <= (kind_in == KIND_WHOLE) ? VALUE_WIDTH'(1) : rd_ff;
      end
   end

   assign kind                = out_kind_ff;
   assign negative            = out_neg_ff;
   assign whole_part          = out_whole_ff;
   assign reduced_numerator   = out_rn_ff;
   assign reduced_denominator = out_rd_ff;

endmodule
`default_nettype wire

### hw/rtl/fmn_ctrl.sv
`default_nettype none
module fmn_ctrl
   import fmn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire status_type  status,
   output cmd_type          cmd
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CHECK  = 9'b000000010,
      ST_DIV_W  = 9'b000000100,
      ST_PREP_G = 9'b000001000,
      ST_GCD    = 9'b000010000,
      ST_DIV_N  = 9'b000100000,
      ST_PREP_D = 9'b001000000,
      ST_DIV_D  = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic                 last;

   assign last       = (cnt_ff == DIV_LAST);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.div_op = DIV_OP_WHOLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.special) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV_W;
            end
         end
         ST_DIV_W: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last) begin
               cmd.div_save = 1'b1;
               state_in     = ST_PREP_G;
            end
         end
         ST_PREP_G: begin
            if (status.rem_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in     = ST_GCD;
            end
         end
         ST_GCD: begin
            cmd.div_op = DIV_OP_NUM;
            if (status.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV_N;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV_N: begin
            cmd.div_op   = DIV_OP_NUM;
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last) begin
               cmd.div_save = 1'b1;
               state_in     = ST_PREP_D;
            end
         end
         ST_PREP_D: begin
            cmd.div_op   = DIV_OP_DEN;
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV_D;
         end
         ST_DIV_D: begin
            cmd.div_op   = DIV_OP_DEN;
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last) begin
               cmd.div_save = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/fraction_to_mixed_number_top.sv
`default_nettype none
// Converts a signed fraction numerator/denominator into a sign, a whole part
// and a proper fraction in lowest terms. One request carries both operands;
// one response carries the kind (not a number, zero, mixed, whole only, proper
// fraction only) in tuser and the sign, whole part, reduced numerator and
// reduced denominator in tdata. Magnitudes are taken as unsigned, so the most
// negative input has magnitude 2^31. Fields a kind does not use are zero, and
// a whole-only result reports 0/1 as its fraction. A zero numerator or
// denominator goes straight to the output register, a division with no
// remainder skips the gcd and both reductions, and otherwise the time grows
// with the data-dependent steps of the binary gcd. One shared bit-serial
// divider is used three times (whole part, then numerator and denominator
// over the gcd), and the gcd takes one step per cycle. Requests are taken one
// at a time; the next request is accepted as soon as the previous result sits
// in the output register, even if not yet taken.
module fraction_to_mixed_number_top
   import fmn_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   // request channel
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [63:0]   req_tdata,   // [31:0] numerator, [63:32] denominator
   // response channel
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [95:0]        rsp_tdata,   // [0] negative, [32:1] whole_part,
                                           // [63:33] reduced_numerator,
                                           // [95:64] reduced_denominator
   output logic [2:0]         rsp_tuser    // [2:0] kind
);

   cmd_type                cmd;
   status_type             status;
   kind_type               kind;
   logic                   negative;
   logic [VALUE_WIDTH-1:0] whole_part;
   logic [VALUE_WIDTH-2:0] reduced_numerator;
   logic [VALUE_WIDTH-1:0] reduced_denominator;

   // sequence the divider and gcd steps, own the handshakes
   fmn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // magnitudes, shared divider, binary gcd and the output register
   fmn_dp u_dp (
      .clock               (clock),
      .cmd                 (cmd),
      .numerator           (req_tdata[31:0]),
      .denominator         (req_tdata[63:32]),
      .status              (status),
      .kind                (kind),
      .negative            (negative),
      .whole_part          (whole_part),
      .reduced_numerator   (reduced_numerator),
      .reduced_denominator (reduced_denominator)
   );

   assign rsp_tuser = kind;
   assign rsp_tdata = {reduced_denominator, reduced_numerator, whole_part, negative};

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import fmn_pkg::*;

   // Run shape
   localparam int RESET_CYCLES   = 12;
   localparam int DIRECTED_ROWS  = 25;
   localparam int RANDOM_ITEMS   = 650;
   localparam int HOLD_OFF_CYCLES = 800;
   localparam int DRAIN_CYCLES   = 250;   // above the worst-case latency
   localparam int WATCHDOG_LIMIT = 4000;  // covers the long hold-off plus slow requests

   // One result as the block reports it, split into fields
   typedef struct packed {
      kind_type    kind;
      logic        negative;
      logic [31:0] whole_part;
      logic [30:0] reduced_num;
      logic [31:0] reduced_den;
   } mixed_number_type;

   // One row of the directed table; the expected result is used only when typed is set
   typedef struct packed {
      logic [31:0]      numerator;
      logic [31:0]      denominator;
      logic             typed;
      mixed_number_type result;
   } directed_row_type;

   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      // zero denominator: not a number, all other fields zero
      '{32'h0000_0000, 32'h0000_0000, 1'b1, '{KIND_NAN, 1'b0, 32'h0, 31'h0, 32'h0}},
      '{32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{KIND_NAN, 1'b0, 32'h0, 31'h0, 32'h0}},
      '{32'h8000_0000, 32'h0000_0000, 1'b1, '{KIND_NAN, 1'b0, 32'h0, 31'h0, 32'h0}},
      // zero numerator: zero kind, sign dropped
      '{32'h0000_0000, 32'h8000_0000, 1'b1, '{KIND_ZERO, 1'b0, 32'h0, 31'h0, 32'h0}},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{KIND_ZERO, 1'b0, 32'h0, 31'h0, 32'h0}},
      // most negative numerator: magnitude 2^31 without overflow
      '{32'h8000_0000, 32'h0000_0001, 1'b1,
        '{KIND_WHOLE, 1'b1, 32'h8000_0000, 31'h0, 32'h1}},
      '{32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
        '{KIND_WHOLE, 1'b0, 32'h8000_0000, 31'h0, 32'h1}},
      '{32'h7FFF_FFFF, 32'h0000_0001, 1'b1,
        '{KIND_WHOLE, 1'b0, 32'h7FFF_FFFF, 31'h0, 32'h1}},
      '{32'h8000_0000, 32'h8000_0000, 1'b1, '{KIND_WHOLE, 1'b0, 32'h1, 31'h0, 32'h1}},
      // proper fractions over the largest denominator, then mixed and whole results
      '{32'h0000_0001, 32'h8000_0000, 1'b1,
        '{KIND_PROPER, 1'b1, 32'h0, 31'h1, 32'h8000_0000}},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
        '{KIND_PROPER, 1'b1, 32'h0, 31'h7FFF_FFFF, 32'h8000_0000}},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
        '{KIND_MIXED, 1'b1, 32'h1, 31'h1, 32'h7FFF_FFFF}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{KIND_WHOLE, 1'b0, 32'h1, 31'h0, 32'h1}},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{KIND_WHOLE, 1'b0, 32'h1, 31'h0, 32'h1}},
      // every sign combination and reductions, checked by prediction
      '{32'd7,         32'd2,         1'b0, '0},
      '{32'hFFFF_FFFA, 32'd4,         1'b0, '0},
      '{32'd6,         32'hFFFF_FFFC, 1'b0, '0},
      '{32'hFFFF_FFFA, 32'hFFFF_FFFC, 1'b0, '0},
      '{32'd2,         32'd4,         1'b0, '0},
      '{32'd12,        32'd18,        1'b0, '0},
      '{32'd30,        32'hFFFF_FFFB, 1'b0, '0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
      '{32'h4000_0000, 32'h00C0_0000, 1'b0, '0},
      '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // [31:0] numerator, [63:32] denominator
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;         // [0] negative, [32:1] whole_part,
                                   // [63:33] reduced_numerator, [95:64] reduced_denominator
   logic [2:0]  rsp_tuser;         // [2:0] kind

   // Request list: directed rows first, random requests after
   logic [31:0]      request_num_q[$];
   logic [31:0]      request_den_q[$];
   bit               request_typed_q[$];
   mixed_number_type request_result_q[$];
   int               total_requests = 0;

   // Results still owed by the block, oldest first
   mixed_number_type owed_results[$];

   int   next_request = 0;   // index of the next request to put on the bus
   int   bus_request  = 0;   // index of the request currently on the bus
   logic hold_off     = 1'b0;
   int   mismatches   = 0;

   fraction_to_mixed_number_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predict the mixed number for one numerator / denominator pair
   function automatic mixed_number_type mixed_number_of(logic [31:0] num, logic [31:0] den);
      mixed_number_type res;
      logic [32:0] mag_num, mag_den, quot, rem, a, b, t;
      res = '0;
      res.kind = KIND_NAN;
      if (den == 32'h0) begin
         res.kind = KIND_NAN;
      end else if (num == 32'h0) begin
         res.kind = KIND_ZERO;
      end else begin
         // take magnitudes one bit wider so that -2^31 stays exact
         mag_num = num[31] ? ({1'b0, ~num} + 33'd1) : {1'b0, num};
         mag_den = den[31] ? ({1'b0, ~den} + 33'd1) : {1'b0, den};
         res.negative = num[31] ^ den[31];
         quot = mag_num / mag_den;
         rem  = mag_num % mag_den;
         res.whole_part = quot[31:0];
         if (rem != 33'd0) begin
            a = rem;
            b = mag_den;
            while (b != 33'd0) begin
               t = a % b;
               a = b;
               b = t;
            end
            quot = rem / a;
            res.reduced_num = quot[30:0];
            quot = mag_den / a;
            res.reduced_den = quot[31:0];
         end else begin
            res.reduced_den = 32'd1;
         end
         if (res.whole_part != 32'd0 && rem != 33'd0) res.kind = KIND_MIXED;
         else if (res.whole_part != 32'd0)            res.kind = KIND_WHOLE;
         else                                         res.kind = KIND_PROPER;
      end
      return res;
   endfunction

   // Flip the sign of a magnitude at random
   function automatic logic [31:0] random_sign(logic [31:0] mag);
      return ($urandom_range(1) != 0) ? -mag : mag;
   endfunction

   function automatic logic [31:0] edge_value(int unsigned pick);
      case (pick)
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0001;
         4:       return 32'h8000_0001;
         default: return $urandom;
      endcase
   endfunction

   // Draw one random request, biased toward shared factors and exact quotients
   task automatic make_random_request(output logic [31:0] num, output logic [31:0] den);
      int unsigned pick, factor, a, b;
      pick = $urandom_range(99);
      if (pick < 25) begin
         num = $urandom;
         den = $urandom;
      end else if (pick < 60) begin
         factor = $urandom_range(1, 1 << $urandom_range(1, 15));
         a = $urandom_range(1, 1 << $urandom_range(0, 16));
         b = $urandom_range(1, 1 << $urandom_range(0, 16));
         num = random_sign(32'(factor * a));
         den = random_sign(32'(factor * b));
      end else if (pick < 75) begin
         num = random_sign($urandom_range(0, 40));
         den = random_sign($urandom_range(0, 40));
      end else if (pick < 85) begin
         a = $urandom_range(1, 1 << $urandom_range(0, 15));
         b = $urandom_range(1, 1 << $urandom_range(0, 15));
         den = random_sign(32'(a));
         num = random_sign(32'(a * b));
      end else if (pick < 90) begin
         if ($urandom_range(1) != 0) begin
            num = 32'h0;
            den = $urandom;
         end else begin
            num = $urandom;
            den = 32'h0;
         end
      end else begin
         num = edge_value($urandom_range(7));
         den = edge_value($urandom_range(7));
      end
   endtask

   // Phase 0: no idling; 1: sender idles; 2: receiver stalls; 3: both
   function automatic int phase_of(int idx);
      int p;
      if (idx < DIRECTED_ROWS) return 0;
      p = (idx - DIRECTED_ROWS) * 4 / RANDOM_ITEMS;
      return (p > 3) ? 3 : p;
   endfunction

   function automatic int sender_idle_pct(int phase);
      case (phase)
         1:       return 47;
         3:       return 34;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct(int phase);
      case (phase)
         2:       return 47;
         3:       return 34;
         default: return 0;
      endcase
   endfunction

   // Sender: record the expected result on acceptance, then offer the next request
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (request_typed_q[bus_request])
               owed_results.push_back(request_result_q[bus_request]);
            else
               owed_results.push_back(mixed_number_of(req_tdata[31:0], req_tdata[63:32]));
         end
         // hold the request while it waits; advance only when the bus is free
         if (!req_tvalid || req_tready) begin
            if (next_request < total_requests &&
                $urandom_range(99) >= sender_idle_pct(phase_of(next_request))) begin
               req_tvalid   <= 1'b1;
               req_tdata    <= {request_den_q[next_request], request_num_q[next_request]};
               bus_request  <= next_request;
               next_request <= next_request + 1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall at random per phase, and throughout the hold-off
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (hold_off)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct(phase_of(next_request)));
   end

   // Hold off the receiver for a long stretch while the sender keeps offering,
   // so that the output register fills and the block stalls its input
   initial begin
      @(negedge clock);
      while (next_request < DIRECTED_ROWS + RANDOM_ITEMS / 4 + 20) @(negedge clock);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Compare every accepted result with the oldest owed one
   always @(posedge clock) begin
      mixed_number_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_results.size() == 0) begin
            $display("%0t: result with no request outstanding, expected none, got %h %h",
                     $time, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = owed_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_tuser));
            check_field("negative", 32'(want.negative), 32'(rsp_tdata[0]));
            check_field("whole_part", want.whole_part, rsp_tdata[32:1]);
            check_field("reduced_numerator", 32'(want.reduced_num), 32'(rsp_tdata[63:33]));
            check_field("reduced_denominator", want.reduced_den, rsp_tdata[95:64]);
         end
      end
   end

   // Watchdog: end the run when no request or result moves for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet = quiet + 1;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [31:0] num, den;
      // walk the directed table into the request list
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         request_num_q.push_back(DIRECTED_TABLE[i].numerator);
         request_den_q.push_back(DIRECTED_TABLE[i].denominator);
         request_typed_q.push_back(DIRECTED_TABLE[i].typed);
         request_result_q.push_back(DIRECTED_TABLE[i].result);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         make_random_request(num, den);
         request_num_q.push_back(num);
         request_den_q.push_back(den);
         request_typed_q.push_back(1'b0);
         request_result_q.push_back('0);
      end
      total_requests = request_num_q.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // drain: every request sent and every owed result received
      do @(negedge clock);
      while (!(next_request == total_requests && !req_tvalid && owed_results.size() == 0));
      // give any stray result time to show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
